/* hdl/overwriting_ring_buffer_macros.svh */
// Assertion shorthands used by the bound assertion checker file.
`ifndef OVERWRITING_RING_BUFFER_MACROS_SVH
`define OVERWRITING_RING_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ORB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ORB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/orb_pkg.sv */
package orb_pkg;

  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 12;
  localparam int LEN_W  = 7;
  localparam int RLEN_W = 13;
  localparam int KIND_W = 2;
  localparam int CFG_AW = 3;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Register index as seen in paddr[2].
  localparam logic REG_RING_LEN = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVAIL,
    ST_SIZE,
    ST_END,
    ST_STREAM
  } orb_state_t;

  typedef struct packed {
    logic             strobe;
    logic             byte_valid;
    logic             last;
    logic [LEN_W-1:0] read_count;
    logic [POS_W-1:0] new_read_pos;
  } orb_res_t;

endpackage

/* hdl/orb_ram.sv */
module orb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/orb_ctrl.sv */
module orb_ctrl
  import orb_pkg::*;
#(
  parameter int AW       = 12,
  parameter int CW       = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] kind,
  input  logic [BYTE_W-1:0] wr_byte,
  input  logic [POS_W-1:0]  read_pos,
  input  logic [LEN_W-1:0]  read_len,
  input  logic              exact_only,
  output logic              busy,
  input  logic [CW-1:0]     ring_len,
  input  logic              cfg_clear,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  output orb_res_t          res
);

  localparam int SW = CW + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_READ);

  orb_state_t       state_r, state_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  orb_res_t         res_r, res_nxt;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] want_r, want_nxt;
  logic             exact_r, exact_nxt;
  logic [CW-1:0]    avail_r, avail_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [AW-1:0]    end_r, end_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;

  logic             accept;
  logic [CW-1:0]    pos_c;
  logic [CW-1:0]    wp_c;
  logic [CW-1:0]    wp_inc;
  logic [CW-1:0]    addr_inc;
  logic [CW-1:0]    want_c;
  logic [SW-1:0]    end_sum;
  logic [LEN_W-1:0] n_c;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign res    = res_r;

  assign pos_c    = CW'(pos_r);
  assign wp_c     = CW'(wp_r);
  assign wp_inc   = wp_c + CW'(1);
  assign addr_inc = CW'(addr_r) + CW'(1);
  assign want_c   = CW'(want_r);
  assign end_sum  = SW'(pos_r) + SW'(n_r);

  always_comb begin
    if (exact_r) begin
      n_c = (avail_r >= want_c) ? want_r : '0;
    end else begin
      n_c = (avail_r < want_c) ? LEN_W'(avail_r) : want_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    res_nxt   = '0;
    pos_nxt   = pos_r;
    want_nxt  = want_r;
    exact_nxt = exact_r;
    avail_nxt = avail_r;
    n_nxt     = n_r;
    end_nxt   = end_r;
    addr_nxt  = addr_r;
    k_nxt     = k_r;
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = wr_byte;
    mem_re    = 1'b0;
    mem_raddr = addr_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_clear) begin
          wp_nxt   = '0;
          fill_nxt = '0;
        end else if (accept) begin
          case (kind)
            KIND_WRITE: begin
              mem_we = 1'b1;
              wp_nxt = (wp_inc >= ring_len) ? '0 : AW'(wp_inc);
              if (fill_r < ring_len) begin
                fill_nxt = fill_r + CW'(1);
              end
            end
            KIND_READ: begin
              pos_nxt   = read_pos;
              want_nxt  = (read_len > MAX_LEN) ? MAX_LEN : read_len;
              exact_nxt = exact_only;
              state_nxt = ST_AVAIL;
            end
            KIND_CLEAR: begin
              wp_nxt   = '0;
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_AVAIL: begin
        // Once the ring has filled, a reader behind the writer sees the wrapped span.
        if (pos_c >= ring_len) begin
          avail_nxt = '0;
        end else if (fill_r < ring_len) begin
          avail_nxt = (wp_c > pos_c) ? (wp_c - pos_c) : '0;
        end else if (wp_c >= pos_c) begin
          avail_nxt = wp_c - pos_c;
        end else begin
          avail_nxt = ring_len - pos_c + wp_c;
        end
        state_nxt = ST_SIZE;
      end

      ST_SIZE: begin
        n_nxt = n_c;
        if (n_c == '0) begin
          res_nxt.strobe       = 1'b1;
          res_nxt.byte_valid   = 1'b0;
          res_nxt.last         = 1'b1;
          res_nxt.read_count   = '0;
          res_nxt.new_read_pos = pos_r;
          state_nxt            = ST_IDLE;
        end else begin
          state_nxt = ST_END;
        end
      end

      ST_END: begin
        end_nxt   = (end_sum >= SW'(ring_len)) ? AW'(end_sum - SW'(ring_len))
                                               : AW'(end_sum);
        addr_nxt  = AW'(pos_r);
        k_nxt     = '0;
        state_nxt = ST_STREAM;
      end

      ST_STREAM: begin
        // The result fields are registered alongside the memory read data.
        mem_re               = 1'b1;
        addr_nxt             = (addr_inc >= ring_len) ? '0 : AW'(addr_inc);
        k_nxt                = k_r + LEN_W'(1);
        res_nxt.strobe       = 1'b1;
        res_nxt.byte_valid   = 1'b1;
        res_nxt.read_count   = n_r;
        res_nxt.new_read_pos = POS_W'(end_r);
        res_nxt.last         = (k_nxt == n_r);
        if (k_nxt == n_r) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    want_r  <= want_nxt;
    exact_r <= exact_nxt;
    avail_r <= avail_nxt;
    n_r     <= n_nxt;
    end_r   <= end_nxt;
    addr_r  <= addr_nxt;
    k_r     <= k_nxt;
  end

endmodule

/* hdl/overwriting_ring_buffer.sv */
// Write and clear items take effect on acceptance; a write can be accepted every
// cycle while no read is in progress. An empty read shows its single result after the
// ST_AVAIL and ST_SIZE states; otherwise ST_END follows and ST_STREAM sends one
// byte per cycle from the single memory read port; busy drops as the last byte appears.
// Synchronous reset clears the write pointer and fill count and sets ring_len to
// DEPTH; the byte store itself is not cleared.
module overwriting_ring_buffer
  import orb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [BYTE_W-1:0] in_wr_byte,
  input  logic [POS_W-1:0]  in_read_pos,
  input  logic [LEN_W-1:0]  in_read_len,
  input  logic              in_exact_only,
  output logic              out_strobe,
  output logic [BYTE_W-1:0] out_rd_byte,
  output logic              out_byte_valid,
  output logic [POS_W-1:0]  out_new_read_pos,
  output logic [LEN_W-1:0]  out_read_count,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW  = POS_W;
  localparam int CW  = RLEN_W;

  logic [CW-1:0]     ring_len_r, ring_len_nxt;
  logic              cfg_wr;
  logic [RLEN_W-1:0] cfg_val;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  orb_res_t          res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_RING_LEN);
  assign cfg_val = pwdata[RLEN_W-1:0];
  assign prdata  = (paddr[2] == REG_RING_LEN) ? 32'(ring_len_r) : '0;

  always_comb begin
    ring_len_nxt = ring_len_r;
    if (cfg_wr) begin
      // Out-of-range lengths fall back to the full store.
      if ((cfg_val == '0) || (CW'(cfg_val) > CW'(DEPTH))) begin
        ring_len_nxt = CW'(DEPTH);
      end else begin
        ring_len_nxt = CW'(cfg_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_len_r <= CW'(DEPTH);
    end else begin
      ring_len_r <= ring_len_nxt;
    end
  end

  orb_ctrl #(
    .AW       (AW),
    .CW       (CW)
  ) u_orb_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .kind       (in_kind),
    .wr_byte    (in_wr_byte),
    .read_pos   (in_read_pos),
    .read_len   (in_read_len),
    .exact_only (in_exact_only),
    .busy       (busy),
    .ring_len   (ring_len_r),
    .cfg_clear  (cfg_wr),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .res        (res)
  );

  orb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (BYTE_W)
  ) u_orb_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_strobe       = res.strobe;
  assign out_byte_valid   = res.byte_valid;
  assign out_last         = res.last;
  assign out_read_count   = res.read_count;
  assign out_new_read_pos = res.new_read_pos;
  assign out_rd_byte      = res.byte_valid ? mem_rdata : '0;

endmodule

/* hdl/orb_checker.sv */
`include "overwriting_ring_buffer_macros.svh"

module orb_sva
  import orb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [KIND_W-1:0] in_kind,
  input logic              out_strobe,
  input logic [BYTE_W-1:0] out_rd_byte,
  input logic              out_byte_valid,
  input logic [POS_W-1:0]  out_new_read_pos,
  input logic [LEN_W-1:0]  out_read_count,
  input logic              out_last
);

  // A request's bytes stream without gaps.
  `ORB_ASSERT_NEXT(a_stream_gapless, out_strobe && !out_last, out_strobe,
                   "gap inside a read transfer")

  // Count and final position are the same on every result of one request.
  `ORB_ASSERT_NEXT(a_stream_fields_hold, out_strobe && !out_last,
                   $stable(out_read_count) && $stable(out_new_read_pos),
                   "read count or position changed mid-request")

  // An empty read is a single, zeroed result.
  `ORB_ASSERT_SAME(a_empty_result, out_strobe && !out_byte_valid,
                   out_last && (out_read_count == '0) && (out_rd_byte == '0),
                   "malformed empty read result")

  // A data byte belongs to a nonzero count.
  `ORB_ASSERT_SAME(a_data_count, out_strobe && out_byte_valid, out_read_count != '0,
                   "data byte with zero count")

  // An accepted read request occupies the block on the next cycle.
  `ORB_ASSERT_NEXT(a_read_busy, start && !busy && (in_kind == KIND_READ), busy,
                   "read request did not raise busy")

endmodule

bind overwriting_ring_buffer orb_sva u_orb_checker (.*);

/* tb/orb_checker.sv */
`timescale 1ns / 1ps

// Watches the command, result and register ports of the ring buffer, keeps its own copy of
// the ring and predicts every byte that a read request streams out.
module orb_checker
  import orb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [BYTE_W-1:0] in_wr_byte,
  input  logic [POS_W-1:0]  in_read_pos,
  input  logic [LEN_W-1:0]  in_read_len,
  input  logic              in_exact_only,
  input  logic              out_strobe,
  input  logic [BYTE_W-1:0] out_rd_byte,
  input  logic              out_byte_valid,
  input  logic [POS_W-1:0]  out_new_read_pos,
  input  logic [LEN_W-1:0]  out_read_count,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       mismatch_count,
  output int unsigned       pending_count
);

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned READ_MAX   = 64;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_byte;
    logic              byte_valid;
    logic [POS_W-1:0]  new_pos;
    logic [LEN_W-1:0]  count;
    logic              last;
  } read_beat_t;

  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned       wr_ptr;
  int unsigned       fill_lvl;
  int unsigned       ring_len;
  read_beat_t        beat_q[$];

  // Bytes a reader at position p may take. A full ring with p at the write pointer has none.
  function automatic int unsigned bytes_ready(input int unsigned p);
    if (p >= ring_len) return 0;
    if (fill_lvl < ring_len) return (wr_ptr > p) ? wr_ptr - p : 0;
    if (wr_ptr >= p) return wr_ptr - p;
    return ring_len - p + wr_ptr;
  endfunction

  task automatic queue_read(input int unsigned pos, input int unsigned len, input logic exact);
    int unsigned want;
    int unsigned avail;
    int unsigned n;
    int unsigned end_pos;
    int unsigned a;
    read_beat_t  b;
    want  = (len > READ_MAX) ? READ_MAX : len;
    avail = bytes_ready(pos);
    if (exact) begin
      n = (avail >= want) ? want : 0;
    end else begin
      n = (avail < want) ? avail : want;
    end
    if (n == 0) begin
      b.rd_byte    = '0;
      b.byte_valid = 1'b0;
      b.new_pos    = pos[POS_W-1:0];
      b.count      = '0;
      b.last       = 1'b1;
      beat_q.push_back(b);
    end else begin
      end_pos = pos + n;
      if (end_pos >= ring_len) end_pos -= ring_len;
      a = pos;
      for (int unsigned k = 0; k < n; k++) begin
        b.rd_byte    = ring_mem[a[POS_W-1:0]];
        b.byte_valid = 1'b1;
        b.new_pos    = end_pos[POS_W-1:0];
        b.count      = n[LEN_W-1:0];
        b.last       = (k + 1 == n);
        beat_q.push_back(b);
        a++;
        if (a >= ring_len) a = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    read_beat_t  got;
    read_beat_t  want_beat;
    int unsigned v;
    if (!rst_n) begin
      wr_ptr         = 0;
      fill_lvl       = 0;
      ring_len       = RING_DEPTH;
      mismatch_count = 0;
      beat_q.delete();
    end else begin
      // A ring length change also empties the ring.
      if (psel && penable && pwrite && pready && paddr[2] == REG_RING_LEN) begin
        v = 32'(pwdata[RLEN_W-1:0]);
        ring_len = (v == 0 || v > RING_DEPTH) ? RING_DEPTH : v;
        wr_ptr   = 0;
        fill_lvl = 0;
      end
      if (start && !busy) begin
        if (in_kind == KIND_WRITE) begin
          ring_mem[wr_ptr[POS_W-1:0]] = in_wr_byte;
          wr_ptr++;
          if (wr_ptr >= ring_len) wr_ptr = 0;
          if (fill_lvl < ring_len) fill_lvl++;
        end else if (in_kind == KIND_CLEAR) begin
          wr_ptr   = 0;
          fill_lvl = 0;
        end else if (in_kind == KIND_READ) begin
          queue_read(32'(in_read_pos), 32'(in_read_len), in_exact_only);
        end
      end
      if (out_strobe) begin
        got = {out_rd_byte, out_byte_valid, out_new_read_pos, out_read_count, out_last};
        if (beat_q.size() == 0) begin
          $display("%0t: unexpected read result: expected none, actual byte %02h valid %0b",
                   $time, out_rd_byte, out_byte_valid);
          mismatch_count++;
        end else begin
          want_beat = beat_q.pop_front();
          if (got !== want_beat) begin
            $display("%0t: read result expected byte %02h valid %0b pos %0d count %0d last %0b",
                     $time, want_beat.rd_byte, want_beat.byte_valid, want_beat.new_pos,
                     want_beat.count, want_beat.last);
            $display("%0t:             actual byte %02h valid %0b pos %0d count %0d last %0b",
                     $time, got.rd_byte, got.byte_valid, got.new_pos, got.count, got.last);
            mismatch_count++;
          end
        end
      end
    end
    pending_count = beat_q.size();
  end

endmodule

/* tb/tb_overwriting_ring_buffer.sv */
`timescale 1ns / 1ps

module tb_overwriting_ring_buffer;
  import orb_pkg::*;

  localparam int unsigned RING_DEPTH   = 4096;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;
  localparam logic [CFG_AW-1:0] ADDR_RING_LEN = {REG_RING_LEN, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [BYTE_W-1:0] in_wr_byte = '0;
  logic [POS_W-1:0]  in_read_pos = '0;
  logic [LEN_W-1:0]  in_read_len = '0;
  logic              in_exact_only = 1'b0;
  logic              out_strobe;
  logic [BYTE_W-1:0] out_rd_byte;
  logic              out_byte_valid;
  logic [POS_W-1:0]  out_new_read_pos;
  logic [LEN_W-1:0]  out_read_count;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       idle_cycles = 0;

  // Stimulus-side view of the ring, used only to aim reads near the write pointer.
  bit                gaps_on = 1'b1;
  int unsigned       cur_len = RING_DEPTH;
  int unsigned       wp_est = 0;
  int unsigned       fill_est = 0;

  always #10 clk = ~clk;

  overwriting_ring_buffer i_dut (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_wr_byte, .in_read_pos, .in_read_len, .in_exact_only,
    .out_strobe, .out_rd_byte, .out_byte_valid, .out_new_read_pos, .out_read_count, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  orb_checker i_checker (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_wr_byte, .in_read_pos, .in_read_len, .in_exact_only,
    .out_strobe, .out_rd_byte, .out_byte_valid, .out_new_read_pos, .out_read_count, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count(mismatches), .pending_count(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("overwriting_ring_buffer: mismatch");
      $finish;
    end
  end

  // Presents one command and holds it until the block takes the transfer.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] wbyte,
                       input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len,
                       input logic exact);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_kind       <= kind;
    in_wr_byte    <= wbyte;
    in_read_pos   <= pos;
    in_read_len   <= len;
    in_exact_only <= exact;
    do @(posedge clk); while (busy);
    if (kind == KIND_WRITE) begin
      wp_est = (wp_est + 1) % cur_len;
      if (fill_est < cur_len) fill_est++;
    end else if (kind == KIND_CLEAR) begin
      wp_est   = 0;
      fill_est = 0;
    end
  endtask

  task automatic write_byte(input logic [BYTE_W-1:0] b);
    issue(KIND_WRITE, b, POS_W'($urandom), LEN_W'($urandom), 1'($urandom));
  endtask

  task automatic read_req(input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len,
                          input logic exact);
    issue(KIND_READ, BYTE_W'($urandom), pos, len, exact);
  endtask

  // Waits until every read result is in and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_ring_len(input logic [31:0] value);
    int unsigned v;
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_RING_LEN;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v        = 32'(value[RLEN_W-1:0]);
    cur_len  = (v == 0 || v > RING_DEPTH) ? RING_DEPTH : v;
    wp_est   = 0;
    fill_est = 0;
  endtask

  // Mostly writes and reads trailing the writer by a random distance, with some stray positions,
  // odd lengths, clears and unused commands mixed in.
  task automatic run_random(input int unsigned n_items);
    int unsigned done;
    int unsigned r;
    int unsigned q;
    int unsigned back;
    int unsigned pos;
    int unsigned len;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        write_byte(BYTE_W'($urandom));
        done++;
      end else if (r < 92) begin
        q = $urandom_range(0, 9);
        if (q < 7) begin
          back = $urandom_range(0, (fill_est < 70) ? fill_est : 70);
          pos  = (wp_est + cur_len - back) % cur_len;
        end else if (q < 9) begin
          pos = $urandom_range(0, cur_len - 1);
        end else begin
          pos = $urandom_range(0, RING_DEPTH - 1);
        end
        q = $urandom_range(0, 19);
        if (q == 0) begin
          len = 0;
        end else if (q == 1) begin
          len = $urandom_range(65, 127);
        end else if (q < 12) begin
          len = $urandom_range(1, 8);
        end else begin
          len = $urandom_range(1, 64);
        end
        read_req(POS_W'(pos), LEN_W'(len), 1'($urandom_range(0, 1)));
        done++;
      end else if (r < 96) begin
        issue(KIND_CLEAR, BYTE_W'($urandom), POS_W'($urandom), LEN_W'($urandom),
              1'($urandom));
        done++;
      end else begin
        issue(KIND_UNUSED, BYTE_W'($urandom), POS_W'($urandom), LEN_W'($urandom),
              1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset length, nothing written yet.
    read_req(12'd0, 7'd5, 1'b0);
    issue(KIND_UNUSED, 8'hFF, 12'hFFF, 7'h7F, 1'b1);
    write_byte(8'h00);
    write_byte(8'hFF);
    write_byte(8'h5A);
    write_byte(8'hA5);
    read_req(12'd0, 7'd3, 1'b0);
    read_req(12'd0, 7'd10, 1'b1);
    read_req(12'd1, 7'd0, 1'b0);
    read_req(12'd0, 7'd127, 1'b0);
    read_req(12'd4095, 7'd1, 1'b0);
    read_req(12'd2, 7'd2, 1'b1);
    issue(KIND_CLEAR, 8'h00, 12'd0, 7'd0, 1'b0);
    read_req(12'd0, 7'd1, 1'b0);

    // Once written, the single-byte ring is full with the reader on the write pointer.
    set_ring_len(32'd1);
    write_byte(8'h7E);
    read_req(12'd0, 7'd1, 1'b0);
    read_req(12'd1, 7'd1, 1'b0);

    set_ring_len(32'd2);
    write_byte(8'h11);
    write_byte(8'h22);
    write_byte(8'h33);
    read_req(12'd0, 7'd2, 1'b0);
    read_req(12'd1, 7'd2, 1'b0);
    write_byte(8'h44);
    read_req(12'd1, 7'd2, 1'b0);

    // Full ring of four: reader on the write pointer, then reads across the wrap.
    set_ring_len(32'd4);
    for (int i = 0; i < 6; i++) write_byte(BYTE_W'(8'hC0 + i));
    read_req(12'd2, 7'd4, 1'b1);
    read_req(12'd3, 7'd4, 1'b0);
    read_req(12'd3, 7'd3, 1'b1);
    read_req(12'd0, 7'd64, 1'b0);

    set_ring_len(32'd4096);
    run_random(33);

    set_ring_len({19'($urandom), 13'd0} | 32'($urandom_range(2, 20)));
    run_random(33);

    gaps_on = 1'b0;
    set_ring_len(32'($urandom_range(3, 12)));
    run_random(33);
    gaps_on = 1'b1;

    set_ring_len({19'($urandom), 13'd0});
    run_random(33);

    set_ring_len(32'($urandom_range(21, 200)));
    run_random(33);

    set_ring_len({19'($urandom), 13'h1FFF});
    run_random(33);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("overwriting_ring_buffer: match");
    end else begin
      $display("overwriting_ring_buffer: mismatch");
    end
    $finish;
  end

endmodule
